// ----- hw/rtl/alpf_pkg.sv -----
`timescale 1ns / 1ps

package alpf_pkg;

  localparam int STORE_DEPTH_DEF = 131072;

  localparam int POS_W  = 17;
  localparam int SMP_W  = 16;
  localparam int NOTE_W = 7;
  localparam int PER_W  = 13;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } alpf_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_FIND,
    ST_PEAK,
    ST_WALK,
    ST_OUT
  } alpf_state_e;

  // Period of the lowest octave, rounded up to whole samples.
  function automatic logic [PER_W-1:0] base_period(logic [3:0] semi);
    logic [PER_W-1:0] per;
    case (semi)
      4'd0:    per = PER_W'(5394);
      4'd1:    per = PER_W'(5092);
      4'd2:    per = PER_W'(4806);
      4'd3:    per = PER_W'(4536);
      4'd4:    per = PER_W'(4282);
      4'd5:    per = PER_W'(4041);
      4'd6:    per = PER_W'(3815);
      4'd7:    per = PER_W'(3601);
      4'd8:    per = PER_W'(3398);
      4'd9:    per = PER_W'(3208);
      4'd10:   per = PER_W'(3028);
      4'd11:   per = PER_W'(2858);
      default: per = PER_W'(2858);
    endcase
    return per;
  endfunction

  // Samples per period of a note; each octave halves it, rounding up.
  function automatic logic [PER_W-1:0] note_period(logic [NOTE_W-1:0] note);
    logic [14:0]      prod;
    logic [3:0]       oct;
    logic [NOTE_W-1:0] semi_full;
    logic [PER_W:0]   sum;
    prod      = 15'(note) * 15'(171);
    oct       = prod[14:11];
    semi_full = note - NOTE_W'(oct) * NOTE_W'(12);
    sum       = (PER_W+1)'(base_period(semi_full[3:0]))
              + (((PER_W+1)'(1) << oct) - (PER_W+1)'(1));
    return PER_W'(sum >> oct);
  endfunction

endpackage

// ----- hw/rtl/alpf_ram.sv -----
`timescale 1ns / 1ps

module alpf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/audio_loop_point_finder.sv -----
`timescale 1ns / 1ps

// Channel  Handshake                Fields
// in       in_valid_i / in_stall_o  opcode_i, position_i, sample_value_i, midi_note_i
// out      out_valid_o / out_stall_i loop_point_o, range_error_o
//
// Writes stream at one per cycle while no search is running. A search scans
// forward for the first crossing (F <= P samples), then P samples for the peak
// (P the note period), then walks back W steps, one store read a cycle.
// Reset clears the control state only; the sample store is not cleared.
// in_stall_o is high for the whole search, longer while a result is stalled;
// a finished result waits in the output register while writes are taken.
module audio_loop_point_finder
  import alpf_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    opcode_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [SMP_W-1:0] sample_value_i,
  input  logic [NOTE_W-1:0]       midi_note_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [POS_W-1:0]        loop_point_o,
  output logic                    range_error_o
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int IW = ((AW > POS_W + 1) ? AW : POS_W + 1) + 2;
  localparam logic [IW-1:0] DEPTH_IDX = IW'(STORE_DEPTH);

  alpf_state_e state_q, state_d;

  logic signed [IW-1:0] pos_q, pos_d;
  logic [NOTE_W-1:0]    note_q, note_d;
  logic [PER_W-1:0]     per_q, per_d;
  logic [PER_W-1:0]     cnt_q, cnt_d;
  logic signed [IW-1:0] rd_idx_q, rd_idx_d;
  logic                 vld_q, vld_d;
  logic signed [IW-1:0] ev_idx_q, ev_idx_d;
  logic                 ev_oor_q, ev_oor_d;
  logic                 have_q, have_d;
  logic                 prv_pos_q, prv_pos_d;
  logic                 prv_oor_q, prv_oor_d;
  logic signed [IW-1:0] first_q, first_d;
  logic signed [SMP_W-1:0] peak_q, peak_d;
  logic signed [IW-1:0] pidx_q, pidx_d;
  logic signed [IW-1:0] scan_q, scan_d;
  logic                 flag_q, flag_d;
  logic                 out_valid_q, out_valid_d;
  logic [POS_W-1:0]     loop_point_q, loop_point_d;
  logic                 range_error_q, range_error_d;

  logic                    ram_we;
  logic [IW-1:0]           wr_idx;
  logic [SMP_W-1:0]        ram_rdata;
  logic signed [SMP_W-1:0] rd_val;
  logic                    val_pos;
  logic                    oor_now;
  logic                    rising;
  logic signed [IW-1:0]    first_nxt;
  logic signed [IW-1:0]    pidx_nxt;

  assign wr_idx  = {{(IW-POS_W){1'b0}}, position_i};
  assign oor_now = rd_idx_q[IW-1] || (unsigned'(rd_idx_q) >= DEPTH_IDX);
  assign rd_val  = ev_oor_q ? '0 : $signed(ram_rdata);
  assign val_pos = !rd_val[SMP_W-1] && (|rd_val);

  alpf_ram #(
    .WIDTH (SMP_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx[AW-1:0]),
    .wdata_i (sample_value_i),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d       = state_q;
    pos_d         = pos_q;
    note_d        = note_q;
    per_d         = per_q;
    cnt_d         = cnt_q;
    rd_idx_d      = rd_idx_q;
    vld_d         = 1'b0;
    ev_idx_d      = ev_idx_q;
    ev_oor_d      = ev_oor_q;
    have_d        = have_q;
    prv_pos_d     = prv_pos_q;
    prv_oor_d     = prv_oor_q;
    first_d       = first_q;
    peak_d        = peak_q;
    pidx_d        = pidx_q;
    scan_d        = scan_q;
    flag_d        = flag_q;
    out_valid_d   = out_valid_q;
    loop_point_d  = loop_point_q;
    range_error_d = range_error_q;
    ram_we        = 1'b0;
    rising        = 1'b0;
    first_nxt     = first_q;
    pidx_nxt      = pidx_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == OP_WRITE) begin
            ram_we = (wr_idx < DEPTH_IDX);
          end else begin
            pos_d   = $signed(wr_idx);
            note_d  = midi_note_i;
            state_d = ST_START;
          end
        end
      end

      ST_START: begin
        per_d    = note_period(note_q);
        cnt_d    = note_period(note_q);
        rd_idx_d = pos_q - IW'(1);
        flag_d   = 1'b0;
        have_d   = 1'b0;
        state_d  = ST_FIND;
      end

      ST_FIND: begin
        // stream forward from start - 1; keep the previous sample's sign
        vld_d    = 1'b1;
        ev_idx_d = rd_idx_q;
        ev_oor_d = oor_now;
        rd_idx_d = rd_idx_q + IW'(1);
        if (vld_q) begin
          prv_pos_d = val_pos;
          prv_oor_d = ev_oor_q;
          if (!have_q) begin
            have_d = 1'b1;
          end else begin
            flag_d = flag_q | ev_oor_q | (val_pos & prv_oor_q);
            cnt_d  = cnt_q - PER_W'(1);
            rising = val_pos & !prv_pos_q;
            if (rising || cnt_q == PER_W'(1)) begin
              first_nxt = rising ? ev_idx_q : pos_q;
              first_d   = first_nxt;
              rd_idx_d  = first_nxt;
              vld_d     = 1'b0;
              cnt_d     = per_q;
              peak_d    = '0;
              pidx_d    = pos_q;
              state_d   = ST_PEAK;
            end
          end
        end
      end

      ST_PEAK: begin
        vld_d    = 1'b1;
        ev_idx_d = rd_idx_q;
        ev_oor_d = oor_now;
        rd_idx_d = rd_idx_q + IW'(1);
        if (vld_q) begin
          flag_d = flag_q | ev_oor_q;
          if (rd_val > peak_q) begin
            peak_d   = rd_val;
            pidx_nxt = ev_idx_q;
          end
          pidx_d = pidx_nxt;
          cnt_d  = cnt_q - PER_W'(1);
          if (cnt_q == PER_W'(1)) begin
            rd_idx_d = pidx_nxt - IW'(1);
            vld_d    = 1'b0;
            have_d   = 1'b0;
            state_d  = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        // stream backward; the held sample is the candidate, the new one its left
        vld_d    = 1'b1;
        ev_idx_d = rd_idx_q;
        ev_oor_d = oor_now;
        rd_idx_d = rd_idx_q - IW'(1);
        if (vld_q) begin
          if (!have_q) begin
            have_d    = 1'b1;
            prv_pos_d = val_pos;
            prv_oor_d = ev_oor_q;
            scan_d    = ev_idx_q;
          end else begin
            flag_d = flag_q | prv_oor_q | (prv_pos_q & ev_oor_q);
            rising = prv_pos_q & !val_pos;
            if (rising || scan_q <= first_q) begin
              vld_d   = 1'b0;
              state_d = ST_OUT;
            end else begin
              prv_pos_d = val_pos;
              prv_oor_d = ev_oor_q;
              scan_d    = ev_idx_q;
            end
          end
        end
      end

      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          loop_point_d  = flag_q ? '0 : scan_q[POS_W-1:0];
          range_error_d = flag_q;
          state_d       = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pos_q         <= '0;
      note_q        <= '0;
      per_q         <= '0;
      cnt_q         <= '0;
      rd_idx_q      <= '0;
      vld_q         <= 1'b0;
      ev_idx_q      <= '0;
      ev_oor_q      <= 1'b0;
      have_q        <= 1'b0;
      prv_pos_q     <= 1'b0;
      prv_oor_q     <= 1'b0;
      first_q       <= '0;
      peak_q        <= '0;
      pidx_q        <= '0;
      scan_q        <= '0;
      flag_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      loop_point_q  <= '0;
      range_error_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      pos_q         <= pos_d;
      note_q        <= note_d;
      per_q         <= per_d;
      cnt_q         <= cnt_d;
      rd_idx_q      <= rd_idx_d;
      vld_q         <= vld_d;
      ev_idx_q      <= ev_idx_d;
      ev_oor_q      <= ev_oor_d;
      have_q        <= have_d;
      prv_pos_q     <= prv_pos_d;
      prv_oor_q     <= prv_oor_d;
      first_q       <= first_d;
      peak_q        <= peak_d;
      pidx_q        <= pidx_d;
      scan_q        <= scan_d;
      flag_q        <= flag_d;
      out_valid_q   <= out_valid_d;
      loop_point_q  <= loop_point_d;
      range_error_q <= range_error_d;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign loop_point_o  = loop_point_q;
  assign range_error_o = range_error_q;

`ifndef ASSERT_OFF
  a_rise_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result appeared outside the output state");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE) && !vld_q)
    else $error("store written during a search");

  a_read_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (state_q == ST_FIND || state_q == ST_PEAK || state_q == ST_WALK))
    else $error("read data tagged valid outside a scan");

  a_peak_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PEAK) |-> !peak_q[SMP_W-1])
    else $error("peak went negative");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |-> (loop_point_o == '0))
    else $error("range error with nonzero loop point");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import alpf_pkg::*;

  localparam int STORE_DEPTH     = STORE_DEPTH_DEF;
  localparam int ITEM_TARGET     = 1550;
  localparam int PAUSE_EVERY     = 400;
  localparam int SETTLE_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT  = 100000;

  typedef struct packed {
    logic [POS_W-1:0] loop_point;
    logic             range_error;
  } loop_result_t;

  typedef struct packed {
    alpf_op_e          op;
    logic [POS_W-1:0]  pos;
    logic [SMP_W-1:0]  val;
    logic [NOTE_W-1:0] note;
    bit                known;
    loop_result_t      result;
  } probe_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [NOTE_W-1:0] note;
  } search_spot_t;

  typedef enum int {
    WAVE_NOISE,
    WAVE_NEG,
    WAVE_POS,
    WAVE_SAW,
    WAVE_EDGE
  } wave_e;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_stall_o;
  logic                    opcode_i       = 1'b0;
  logic [POS_W-1:0]        position_i     = '0;
  logic signed [SMP_W-1:0] sample_value_i = '0;
  logic [NOTE_W-1:0]       midi_note_i    = '0;
  logic                    out_valid_o;
  logic                    out_stall_i    = 1'b0;
  logic [POS_W-1:0]        loop_point_o;
  logic                    range_error_o;

  // Result typed in by the directed table, travels with the request
  bit           known_valid  = 1'b0;
  loop_result_t known_result = '0;

  bit calm = 1'b0;

  logic signed [SMP_W-1:0] sample_mem [STORE_DEPTH];
  bit                      written_map [STORE_DEPTH];
  bit                      read_outside;

  loop_result_t pending_loops [$];
  search_spot_t past_spots [$];

  int mismatches     = 0;
  int accepted_items = 0;
  int searches_seen  = 0;
  int range_hits     = 0;
  int samples_written = 0;
  int quiet_cycles   = 0;

  // Low-address region exercises the bottom edge and the special walks;
  // the two top searches exercise reads past the end of the store.
  probe_t probe_rows [19] = '{
    '{OP_WRITE,  17'd0,      16'h7FFF, 7'd0,   1'b0, '{17'd0, 1'b0}},
    '{OP_WRITE,  17'd1,      16'h8000, 7'd0,   1'b0, '{17'd0, 1'b0}},
    '{OP_WRITE,  17'd2,      16'h0000, 7'd0,   1'b0, '{17'd0, 1'b0}},
    '{OP_WRITE,  17'd3,      16'hFFFF, 7'd0,   1'b0, '{17'd0, 1'b0}},
    '{OP_WRITE,  17'd4,      16'hFFEC, 7'd0,   1'b0, '{17'd0, 1'b0}},
    '{OP_WRITE,  17'd5,      16'h0000, 7'd0,   1'b0, '{17'd0, 1'b0}},
    '{OP_WRITE,  17'd6,      16'h0005, 7'd0,   1'b0, '{17'd0, 1'b0}},
    '{OP_WRITE,  17'd7,      16'h0009, 7'd0,   1'b0, '{17'd0, 1'b0}},
    '{OP_WRITE,  17'd8,      16'h0028, 7'd0,   1'b0, '{17'd0, 1'b0}},
    '{OP_WRITE,  17'd9,      16'h0014, 7'd0,   1'b0, '{17'd0, 1'b0}},
    '{OP_WRITE,  17'd10,     16'h0002, 7'd0,   1'b0, '{17'd0, 1'b0}},
    '{OP_SEARCH, 17'd0,      16'h0000, 7'd127, 1'b1, '{17'd0, 1'b1}},
    '{OP_SEARCH, 17'd2,      16'h0000, 7'd127, 1'b0, '{17'd0, 1'b0}},
    '{OP_SEARCH, 17'd3,      16'h0000, 7'd127, 1'b0, '{17'd0, 1'b0}},
    '{OP_SEARCH, 17'd7,      16'h0000, 7'd127, 1'b0, '{17'd0, 1'b0}},
    '{OP_WRITE,  17'd131070, 16'h0000, 7'd0,   1'b0, '{17'd0, 1'b0}},
    '{OP_WRITE,  17'd131071, 16'hFFFF, 7'd0,   1'b0, '{17'd0, 1'b0}},
    '{OP_SEARCH, 17'd131071, 16'h0000, 7'd0,   1'b1, '{17'd0, 1'b1}},
    '{OP_SEARCH, 17'd131070, 16'h0000, 7'd127, 1'b1, '{17'd0, 1'b1}}
  };

  audio_loop_point_finder #(
    .STORE_DEPTH(STORE_DEPTH)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .position_i    (position_i),
    .sample_value_i(sample_value_i),
    .midi_note_i   (midi_note_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .loop_point_o  (loop_point_o),
    .range_error_o (range_error_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Samples per period of a note, rounded up; higher octaves halve it
  function automatic int note_span(logic [NOTE_W-1:0] note);
    int oct, semi;
    longint unsigned num, den;
    oct  = int'(note) / 12;
    semi = int'(note) % 12;
    case (semi)
      0:       num = 64'd5393968278;
      1:       num = 64'd5091228101;
      2:       num = 64'd4805479424;
      3:       num = 64'd4535768589;
      4:       num = 64'd4281195460;
      5:       num = 64'd4040910422;
      6:       num = 64'd3814111547;
      7:       num = 64'd3600041915;
      8:       num = 64'd3397987088;
      9:       num = 64'd3207272727;
      10:      num = 64'd3027262341;
      default: num = 64'd2857355162;
    endcase
    den = 64'd1000000 << oct;
    return int'((num + den - 64'd1) / den);
  endfunction

  function automatic int fetch_sample(int idx);
    if (idx < 0 || idx >= STORE_DEPTH) begin
      read_outside = 1'b1;
      return 0;
    end
    return int'(sample_mem[idx]);
  endfunction

  // Read the previous entry only when the current one is positive
  function automatic bit rises_at(int s);
    if (fetch_sample(s) > 0) return fetch_sample(s - 1) <= 0;
    return 1'b0;
  endfunction

  function automatic loop_result_t predict_loop_point(logic [POS_W-1:0] start,
                                                      logic [NOTE_W-1:0] note);
    int per, first, s, peak, idx, v;
    loop_result_t res;
    read_outside = 1'b0;
    per   = note_span(note);
    first = int'(start);
    for (s = int'(start); s < int'(start) + per; s++) begin
      if (rises_at(s)) begin
        first = s;
        break;
      end
    end
    peak = 0;
    idx  = int'(start);
    for (s = first; s < first + per; s++) begin
      v = fetch_sample(s);
      if (v > peak) begin
        peak = v;
        idx  = s;
      end
    end
    // Step down at least once, stop at the first crossing found
    do begin
      idx--;
      if (rises_at(idx)) break;
    end while (idx > first);
    res.range_error = read_outside;
    res.loop_point  = read_outside ? '0 : POS_W'(idx);
    return res;
  endfunction

  function automatic logic [SMP_W-1:0] wave_sample(wave_e shape, int k, int per, int amp);
    int v;
    case (shape)
      WAVE_NEG: v = -int'($urandom_range(0, 32768));
      WAVE_POS: v = int'($urandom_range(1, 32767));
      WAVE_SAW: begin
        v = (amp * (2 * (k % per) - per)) / per + int'($urandom_range(0, 6)) - 3;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
      WAVE_EDGE: begin
        case ($urandom_range(0, 4))
          0:       v = -32768;
          1:       v = -1;
          2:       v = 0;
          3:       v = 1;
          default: v = 32767;
        endcase
      end
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return SMP_W'(v);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  task automatic send_request(input alpf_op_e op, input int pos,
                              input logic [SMP_W-1:0] val, input logic [NOTE_W-1:0] note,
                              input bit known = 1'b0, input loop_result_t result = '0);
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    position_i     <= POS_W'(pos);
    sample_value_i <= val;
    midi_note_i    <= note;
    known_valid    <= known;
    known_result   <= result;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold off new requests until every search result is back
  task automatic drain_loops();
    in_valid_i <= 1'b0;
    while (pending_loops.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 11);
  end

  always @(posedge clk_i) begin
    loop_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_loops.size() == 0) begin
          report_mismatch($sformatf("result %0d err %0b with no search pending",
                                    loop_point_o, range_error_o));
        end else begin
          want = pending_loops.pop_front();
          if (loop_point_o !== want.loop_point)
            report_mismatch($sformatf("loop_point %0d, want %0d",
                                      loop_point_o, want.loop_point));
          if (range_error_o !== want.range_error)
            report_mismatch($sformatf("range_error %0b, want %0b",
                                      range_error_o, want.range_error));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        accepted_items++;
        if (opcode_i == OP_WRITE) begin
          if (int'(position_i) < STORE_DEPTH) begin
            sample_mem[position_i]  = sample_value_i;
            written_map[position_i] = 1'b1;
          end
          samples_written++;
        end else begin
          want = known_valid ? known_result : predict_loop_point(position_i, midi_note_i);
          pending_loops.push_back(want);
          searches_seen++;
          if (want.range_error) range_hits++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int           per, pos, lo, hi, a, pick, amp, offset, next_pause;
    logic [NOTE_W-1:0] note;
    wave_e        shape;
    search_spot_t spot;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (probe_rows[k]) begin
      send_request(probe_rows[k].op, int'(probe_rows[k].pos),
                   probe_rows[k].op == OP_SEARCH ? SMP_W'($urandom) : probe_rows[k].val,
                   probe_rows[k].op == OP_WRITE ? NOTE_W'($urandom) : probe_rows[k].note,
                   probe_rows[k].known, probe_rows[k].result);
    end
    drain_loops();

    next_pause = accepted_items + PAUSE_EVERY;
    while (accepted_items < ITEM_TARGET) begin
      if (accepted_items >= next_pause) begin
        drain_loops();
        next_pause += PAUSE_EVERY;
      end
      calm = (accepted_items >= 700 && accepted_items < 950);
      pick = int'($urandom_range(0, 99));
      if (pick < 72) begin
        // Fill the whole read window of one search, then search it
        pick = int'($urandom_range(0, 99));
        if (pick < 10) begin
          note = NOTE_W'($urandom_range(0, 127));
          pos  = STORE_DEPTH - int'($urandom_range(1, 12));
        end else begin
          note = ($urandom_range(0, 99) < 85) ? NOTE_W'($urandom_range(100, 127))
                                              : NOTE_W'($urandom_range(84, 99));
          per  = note_span(note);
          pos  = (pick < 20) ? int'($urandom_range(0, 3))
                             : int'($urandom_range(2, STORE_DEPTH - 2 * per - 2));
        end
        per = note_span(note);
        lo  = (pos - 2 < 0) ? 0 : pos - 2;
        hi  = (pos + 2 * per - 2 > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : pos + 2 * per - 2;
        pick  = int'($urandom_range(0, 99));
        shape = pick < 45 ? WAVE_SAW : pick < 70 ? WAVE_NOISE : pick < 80 ? WAVE_NEG :
                pick < 90 ? WAVE_POS : WAVE_EDGE;
        amp    = int'($urandom_range(1, 32767));
        offset = int'($urandom_range(0, 4095));
        for (a = lo; a <= hi; a++) begin
          if (!written_map[a] || $urandom_range(0, 1) == 1)
            send_request(OP_WRITE, a, wave_sample(shape, a + offset, per, amp),
                         NOTE_W'($urandom));
        end
        send_request(OP_SEARCH, pos, SMP_W'($urandom), note);
        if (past_spots.size() < 64) past_spots.push_back('{POS_W'(pos), note});
      end else if (pick < 84 && past_spots.size() != 0) begin
        // Search a window again after noise writes may have changed it
        spot = past_spots[$urandom_range(0, past_spots.size() - 1)];
        send_request(OP_SEARCH, int'(spot.pos), SMP_W'($urandom), spot.note);
      end else begin
        repeat ($urandom_range(1, 6))
          send_request(OP_WRITE, int'($urandom_range(0, STORE_DEPTH - 1)),
                       SMP_W'($urandom), NOTE_W'($urandom));
      end
    end
    calm = 1'b0;
    drain_loops();
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("Run covered %0d loop searches (%0d out of store range) among %0d requests,",
             searches_seen, range_hits, accepted_items);
    $display("with %0d sample writes and %0d mismatches.", samples_written, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
